[sv/joint_motion_profile_sampler_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the joint motion profile sampler.
// Every macro samples on clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef JOINT_MOTION_PROFILE_SAMPLER_UNIT_DEFINES_SVH
`define JOINT_MOTION_PROFILE_SAMPLER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JMPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JMPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/jmps_pkg.sv]
// ----------------------------------------------------------------------------
// jmps_pkg
// Shared constants, codes, types and helper functions of the joint motion
// profile sampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jmps_pkg;

    localparam int INDEX_WIDTH_DEF = 20;
    localparam int ADDR_W          = 4;
    localparam int MAG_W           = 33;
    localparam int QUOT_W          = 35;
    localparam int POSQ_W          = 34;

    localparam logic [QUOT_W-1:0] MAG_CAP = 35'h4_0000_0000;
    localparam logic [30:0]       ONE_Q30 = 31'h4000_0000;

    localparam logic [1:0] MODE_HOLD    = 2'd0;
    localparam logic [1:0] MODE_LINEAR  = 2'd1;
    localparam logic [1:0] MODE_QUINTIC = 2'd2;
    localparam logic [1:0] MODE_BAD     = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_PAST    = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_DUP     = 2'd3;

    localparam logic [1:0] REG_MODE     = 2'd0;
    localparam logic [1:0] REG_DURATION = 2'd1;
    localparam logic [1:0] REG_STEP     = 2'd2;

    localparam logic [1:0]  MODE_RESET     = MODE_QUINTIC;
    localparam logic [31:0] DURATION_RESET = 32'd65536;
    localparam logic [31:0] STEP_RESET     = 32'd655;

    typedef struct packed {
        logic [31:0]        t;
        logic               last;
        logic [1:0]         status;
        logic               neg;
        logic [MAG_W-1:0]   mag;
        logic signed [31:0] q0;
    } ctx_t;

    typedef struct packed {
        ctx_t              base;
        logic [POSQ_W-1:0] posq;
    } ctxq_t;

    typedef struct packed {
        logic [31:0]        t;
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic signed [31:0] acc;
        logic               last;
        logic [1:0]         status;
    } res_t;

    // Q1.30 product rounded to nearest; both operands are at most one.
    function automatic logic [30:0] mulq(input logic [30:0] a, input logic [30:0] b);
        logic [62:0] p;
        p = 63'(a) * 63'(b) + 63'(ONE_Q30 >> 1);
        return p[60:30];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
        if (v > 37'sd2147483647)
            return 32'sh7fff_ffff;
        else if (v < -37'sd2147483648)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

endpackage

[sv/jmps_div.sv]
// ----------------------------------------------------------------------------
// jmps_div
// Pipelined restoring divider, one quotient bit per stage. Returns
// floor(n/c) limited to the magnitude cap, with a side word carried along.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jmps_div #(
    parameter int NW     = 70,
    parameter int CW     = 46,
    parameter int SIDE_W = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [NW-1:0]               n,
    input  logic [CW-1:0]               c,
    input  logic [SIDE_W-1:0]           side_in,
    output logic                        out_valid,
    output logic [jmps_pkg::QUOT_W-1:0] q,
    output logic [SIDE_W-1:0]           side_out
);
    import jmps_pkg::*;

    logic [CW-1:0]     rem_reg  [0:QUOT_W-1];
    logic [QUOT_W-1:0] low_reg  [0:QUOT_W-1];
    logic [CW-1:0]     div_reg  [0:QUOT_W-1];
    logic [QUOT_W-1:0] quo_reg  [0:QUOT_W];
    logic              cap_reg  [0:QUOT_W];
    logic              vld_reg  [0:QUOT_W];
    logic [SIDE_W-1:0] side_reg [0:QUOT_W];

    logic [NW+CW-1:0] hi_ext;
    logic [NW+CW-1:0] c_ext;

    // If the top part of the dividend already reaches the divisor, the
    // quotient is beyond the cap and the remaining bits do not matter.
    assign hi_ext = (NW+CW)'(n >> QUOT_W);
    assign c_ext  = (NW+CW)'(c);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= hi_ext[CW-1:0];
            low_reg[0]  <= n[QUOT_W-1:0];
            div_reg[0]  <= c;
            quo_reg[0]  <= '0;
            cap_reg[0]  <= (hi_ext >= c_ext);
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 0; k < QUOT_W; k++)
    begin : g_stage
        logic [CW:0]   sh;
        logic [CW+1:0] df;
        logic          tk;

        assign sh = {rem_reg[k], low_reg[k][QUOT_W-1]};
        assign df = {1'b0, sh} - {2'b00, div_reg[k]};
        assign tk = !df[CW+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else if (en)
                vld_reg[k+1] <= vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[k+1]  <= {quo_reg[k][QUOT_W-2:0], tk};
                cap_reg[k+1]  <= cap_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end

        if (k < QUOT_W-1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1] <= tk ? df[CW-1:0] : sh[CW-1:0];
                    low_reg[k+1] <= {low_reg[k][QUOT_W-2:0], 1'b0};
                    div_reg[k+1] <= div_reg[k];
                end
            end
        end
    end

    assign out_valid = vld_reg[QUOT_W];
    assign side_out  = side_reg[QUOT_W];
    assign q = (cap_reg[QUOT_W] || quo_reg[QUOT_W] > MAG_CAP) ? MAG_CAP : quo_reg[QUOT_W];

endmodule

[sv/jmps_poly.sv]
// ----------------------------------------------------------------------------
// jmps_poly
// Five-stage evaluation of the smoothstep polynomial and its first two
// derivatives from the normalised time s in Q1.30.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jmps_poly #(
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [30:0]       s_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [30:0]       h,
    output logic [34:0]       dh,
    output logic [38:0]       d2h_mag,
    output logic              d2h_neg,
    output logic [SIDE_W-1:0] side_out
);
    import jmps_pkg::*;

    logic              vld_reg  [1:5];
    logic [SIDE_W-1:0] side_reg [1:5];

    logic [30:0] s1_reg, s2_1_reg, u1_reg;
    logic [30:0] s_2_reg, s2_2_reg, s3_2_reg, uu_2_reg;
    logic [30:0] s_3_reg, s3_3_reg, s4_3_reg, x_3_reg;
    logic signed [39:0] d2h_3_reg, d2h_4_reg;
    logic [30:0] s3_4_reg, s4_4_reg, s5_4_reg;
    logic [34:0] dh_4_reg, dh_5_reg;
    logic [30:0] h_5_reg;
    logic [38:0] d2h_mag_5_reg;
    logic        d2h_neg_5_reg;

    logic signed [39:0] d2h_c;
    logic signed [37:0] h_c;
    logic [39:0]        d2h_abs;

    assign d2h_c = $signed(40'(s_2_reg)) * 40'sd60 - $signed(40'(s2_2_reg)) * 40'sd180
                 + $signed(40'(s3_2_reg)) * 40'sd120;
    assign h_c = $signed(38'(s3_4_reg)) * 38'sd10 - $signed(38'(s4_4_reg)) * 38'sd15
               + $signed(38'(s5_4_reg)) * 38'sd6;
    assign d2h_abs = d2h_4_reg[39] ? 40'(-d2h_4_reg) : 40'(d2h_4_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= 5; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[1] <= in_valid;
            for (int k = 2; k <= 5; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[1] <= side_in;
            for (int k = 2; k <= 5; k++)
                side_reg[k] <= side_reg[k-1];

            s1_reg   <= s_in;
            s2_1_reg <= mulq(s_in, s_in);
            u1_reg   <= ONE_Q30 - s_in;

            s_2_reg  <= s1_reg;
            s2_2_reg <= s2_1_reg;
            s3_2_reg <= mulq(s2_1_reg, s1_reg);
            uu_2_reg <= mulq(u1_reg, u1_reg);

            s_3_reg   <= s_2_reg;
            s3_3_reg  <= s3_2_reg;
            s4_3_reg  <= mulq(s3_2_reg, s_2_reg);
            x_3_reg   <= mulq(s2_2_reg, uu_2_reg);
            d2h_3_reg <= d2h_c;

            s3_4_reg  <= s3_3_reg;
            s4_4_reg  <= s4_3_reg;
            s5_4_reg  <= mulq(s4_3_reg, s_3_reg);
            dh_4_reg  <= 35'(x_3_reg) * 35'd30;
            d2h_4_reg <= d2h_3_reg;

            // The polynomial is clamped to the unit interval.
            if (h_c < 0)
                h_5_reg <= '0;
            else if (h_c > $signed(38'(ONE_Q30)))
                h_5_reg <= ONE_Q30;
            else
                h_5_reg <= h_c[30:0];
            dh_5_reg      <= dh_4_reg;
            d2h_mag_5_reg <= d2h_abs[38:0];
            d2h_neg_5_reg <= d2h_4_reg[39];
        end
    end

    assign out_valid = vld_reg[5];
    assign side_out  = side_reg[5];
    assign h         = h_5_reg;
    assign dh        = dh_5_reg;
    assign d2h_mag   = d2h_mag_5_reg;
    assign d2h_neg   = d2h_neg_5_reg;

endmodule

[sv/joint_motion_profile_sampler_unit.sv]
// ----------------------------------------------------------------------------
// joint_motion_profile_sampler_unit
// Samples a hold, linear or quintic smoothstep joint move: time, position,
// velocity and acceleration for one sample index per word.
// ----------------------------------------------------------------------------
//   channel   handshake            payload
//   config    psel/penable/pready  paddr, pwdata, prdata
//   input     in_valid/in_ready    step_index, start_pos, end_pos
//   output    out_valid/out_ready  sample_time, position, velocity,
//                                  acceleration, is_last, status
//
// One word is accepted every cycle while the skid stage is empty. On the way
// to the output register each word passes two 36-register quotient pipelines in turn.
// The output register and a one-word skid stage let the pipeline keep
// accepting while a result waits; the whole pipeline halts only when the
// skid stage is full. Reset clears the valid bits and sets the registers
// to their reset values; no clearing pass is needed.
`timescale 1ns / 1ps
`include "joint_motion_profile_sampler_unit_defines.svh"

module joint_motion_profile_sampler_unit #(
    parameter int INDEX_WIDTH = jmps_pkg::INDEX_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [jmps_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [INDEX_WIDTH-1:0]      step_index,
    input  logic signed [31:0]          start_pos,
    input  logic signed [31:0]          end_pos,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [31:0]                 sample_time,
    output logic signed [31:0]          position,
    output logic signed [31:0]          velocity,
    output logic signed [31:0]          acceleration,
    output logic                        is_last,
    output logic [1:0]                  status
);
    import jmps_pkg::*;

    localparam int PW     = INDEX_WIDTH + 32;
    localparam int NW_S   = 63;
    localparam int NW_A   = 70;
    localparam int CW_A   = 46;
    localparam int NW_B   = 76;
    localparam int CW_B   = 64;
    localparam int CTX_W  = $bits(ctx_t);
    localparam int CTXQ_W = $bits(ctxq_t);

    // ---------------- configuration registers ----------------
    logic [1:0]  mode_reg;
    logic [31:0] dur_reg, step_reg;
    logic [63:0] dd_reg;
    logic        cfg_bad, lin, quin;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_RESET;
            dur_reg  <= DURATION_RESET;
            step_reg <= STEP_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_MODE:     mode_reg <= pwdata[1:0];
                REG_DURATION: dur_reg  <= pwdata;
                REG_STEP:     step_reg <= pwdata;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_MODE:     prdata = {30'b0, mode_reg};
            REG_DURATION: prdata = dur_reg;
            REG_STEP:     prdata = step_reg;
            default:      prdata = 32'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        dd_reg <= 64'(dur_reg) * 64'(dur_reg);
    end

    assign cfg_bad = (step_reg == 32'b0) || (mode_reg == MODE_BAD)
                   || (mode_reg != MODE_HOLD && dur_reg == 32'b0);
    assign lin  = (mode_reg == MODE_LINEAR);
    assign quin = (mode_reg == MODE_QUINTIC);

    // ---------------- stall control ----------------
    logic en;
    logic skid_valid_reg, out_valid_reg;
    res_t skid_reg, out_reg;

    assign en       = !skid_valid_reg;
    assign in_ready = en;

    // ---------------- stage 1: difference and i*dt ----------------
    logic signed [32:0] delta;
    logic               v1_reg;
    logic [PW-1:0]      p1_reg;
    logic [MAG_W-1:0]   mag1_reg;
    logic               neg1_reg, nz1_reg, ge2_reg, one1_reg;
    logic signed [31:0] q0_1_reg;

    assign delta = $signed({end_pos[31], end_pos}) - $signed({start_pos[31], start_pos});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg   <= PW'(step_index) * PW'(step_reg);
            neg1_reg <= delta[32];
            mag1_reg <= delta[32] ? MAG_W'(-delta) : MAG_W'(delta);
            q0_1_reg <= start_pos;
            nz1_reg  <= (step_index != '0);
            ge2_reg  <= (step_index > INDEX_WIDTH'(1));
            one1_reg <= (step_index == INDEX_WIDTH'(1));
        end
    end

    // ---------------- stage 2: range checks and sample time ----------------
    // The index is past the end exactly when (i-1)*dt already reaches the
    // duration, which avoids working out the step count itself.
    logic [PW-1:0] d_ext, pm;
    logic          past, last_c;
    logic [1:0]    st_c;
    ctx_t          ctx_c, ctx2_reg;
    logic          v2_reg;

    assign d_ext  = PW'(dur_reg);
    assign pm     = p1_reg - PW'(step_reg);
    assign past   = ge2_reg && (pm >= d_ext);
    assign last_c = nz1_reg && !past && (p1_reg >= d_ext);

    always_comb
    begin
        if (cfg_bad)
            st_c = ST_INVALID;
        else if (past)
            st_c = ST_PAST;
        else if (mode_reg == MODE_HOLD && dur_reg == 32'b0 && one1_reg)
            st_c = ST_DUP;
        else
            st_c = ST_OK;
        ctx_c.t      = (p1_reg > d_ext) ? dur_reg : p1_reg[31:0];
        ctx_c.last   = last_c;
        ctx_c.status = st_c;
        ctx_c.neg    = neg1_reg;
        ctx_c.mag    = mag1_reg;
        ctx_c.q0     = q0_1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            ctx2_reg <= ctx_c;
    end

    // ---------------- normalised time s = round(t*2^30/D) ----------------
    logic [NW_S-1:0]   ns;
    logic              vs;
    logic [QUOT_W-1:0] qs;
    logic [CTX_W-1:0]  side_s;
    logic [30:0]       s_val;

    assign ns    = NW_S'({ctx2_reg.t, 30'b0}) + NW_S'(dur_reg >> 1);
    assign s_val = (qs > QUOT_W'(ONE_Q30)) ? ONE_Q30 : qs[30:0];

    jmps_div #(.NW(NW_S), .CW(32), .SIDE_W(CTX_W)) u_div_s (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v2_reg), .n(ns), .c(dur_reg), .side_in(ctx2_reg),
        .out_valid(vs), .q(qs), .side_out(side_s)
    );

    // ---------------- smoothstep polynomial ----------------
    logic             vp, d2h_neg;
    logic [30:0]      h_val;
    logic [34:0]      dh_val;
    logic [38:0]      d2h_mag;
    logic [CTX_W-1:0] side_p;
    ctx_t             ctxp;

    jmps_poly #(.SIDE_W(CTX_W)) u_poly (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(vs), .s_in(s_val), .side_in(side_s),
        .out_valid(vp), .h(h_val), .dh(dh_val), .d2h_mag(d2h_mag),
        .d2h_neg(d2h_neg), .side_out(side_p)
    );

    assign ctxp = side_p;

    // ---------------- products ahead of the second quotients ----------------
    // Linear mode reuses both quotient pipelines: position and velocity.
    logic [34:0] op_a;
    logic [40:0] op_b;
    logic        v3_reg, accneg3_reg;
    logic [67:0] prod_a_reg;
    logic [73:0] prod_b_reg;
    logic [63:0] prod_p_reg;
    ctx_t        ctx3_reg;

    assign op_a = lin ? 35'(ctxp.t) : dh_val;
    assign op_b = lin ? 41'(32'h0001_0000) : {d2h_mag, 2'b00};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= vp;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_a_reg  <= 68'(ctxp.mag) * 68'(op_a);
            prod_b_reg  <= 74'(ctxp.mag) * 74'(op_b);
            prod_p_reg  <= 64'(ctxp.mag) * 64'(h_val);
            ctx3_reg    <= ctxp;
            accneg3_reg <= ctxp.neg ^ d2h_neg;
        end
    end

    logic [CW_A-1:0]   c_a;
    logic [CW_B-1:0]   c_b;
    logic [NW_A-1:0]   n_a;
    logic [NW_B-1:0]   n_b;
    logic [63:0]       posr;
    ctxq_t             ctxq_in, ctxq_out;
    logic [CTXQ_W-1:0] side_a;
    logic              va, vb, accneg;
    logic [QUOT_W-1:0] qa, qb;

    assign c_a  = lin ? CW_A'(dur_reg) : {dur_reg, 14'b0};
    assign c_b  = lin ? CW_B'(dur_reg) : dd_reg;
    assign n_a  = NW_A'(prod_a_reg) + NW_A'(c_a >> 1);
    assign n_b  = NW_B'(prod_b_reg) + NW_B'(c_b >> 1);
    assign posr = prod_p_reg + 64'(ONE_Q30 >> 1);

    always_comb
    begin
        ctxq_in.base = ctx3_reg;
        ctxq_in.posq = posr[63:30];
    end

    jmps_div #(.NW(NW_A), .CW(CW_A), .SIDE_W(CTXQ_W)) u_div_a (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v3_reg), .n(n_a), .c(c_a), .side_in(ctxq_in),
        .out_valid(va), .q(qa), .side_out(side_a)
    );

    jmps_div #(.NW(NW_B), .CW(CW_B), .SIDE_W(1)) u_div_b (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v3_reg), .n(n_b), .c(c_b), .side_in(accneg3_reg),
        .out_valid(vb), .q(qb), .side_out(accneg)
    );

    assign ctxq_out = side_a;

    // ---------------- final signs, saturation and special cases ----------------
    logic [QUOT_W-1:0]  mag_p, mag_v;
    logic signed [36:0] sp, sv, sa;
    res_t               fin;

    always_comb
    begin
        mag_p = lin ? qa : QUOT_W'(ctxq_out.posq);
        mag_v = lin ? qb : qa;
        sp = $signed(37'(mag_p));
        sv = $signed(37'(mag_v));
        sa = $signed(37'(qb));
        if (ctxq_out.base.neg)
        begin
            sp = -sp;
            sv = -sv;
        end
        if (accneg)
            sa = -sa;

        fin.t      = ctxq_out.base.t;
        fin.last   = ctxq_out.base.last;
        fin.status = ctxq_out.base.status;
        if (lin || quin)
        begin
            fin.pos = sat32($signed({{5{ctxq_out.base.q0[31]}}, ctxq_out.base.q0}) + sp);
            fin.vel = sat32(sv);
            fin.acc = quin ? sat32(sa) : 32'sd0;
        end
        else
        begin
            fin.pos = ctxq_out.base.q0;
            fin.vel = 32'sd0;
            fin.acc = 32'sd0;
        end
        if (ctxq_out.base.status != ST_OK)
        begin
            fin.t   = 32'b0;
            fin.pos = 32'sd0;
            fin.vel = 32'sd0;
            fin.acc = 32'sd0;
            if (ctxq_out.base.status != ST_DUP)
                fin.last = 1'b0;
        end
    end

    // ---------------- output register and skid stage ----------------
    logic out_valid_next, skid_valid_next;
    res_t out_next, skid_next;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_next = 1'b0;
            if (va)
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = fin;
                    out_valid_next = 1'b1;
                end
                else
                begin
                    skid_next       = fin;
                    skid_valid_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid    = out_valid_reg;
    assign sample_time  = out_reg.t;
    assign position     = out_reg.pos;
    assign velocity     = out_reg.vel;
    assign acceleration = out_reg.acc;
    assign is_last      = out_reg.last;
    assign status       = out_reg.status;

    // ---------------- assertions ----------------
    `JMPS_ASSERT_NOW(a_skid_needs_out, skid_valid_reg, out_valid_reg, "skid word without output word")
    `JMPS_ASSERT_NOW(a_div_lockstep, 1'b1, va == vb, "quotient pipelines out of step")
    `JMPS_ASSERT_NEXT(a_skid_holds, skid_valid_reg && !out_ready, skid_valid_reg && $stable(skid_reg), "skid word lost while stalled")
    `JMPS_ASSERT_NOW(a_invalid_zero, out_valid_reg && out_reg.status == ST_INVALID, out_reg.pos == 32'sd0 && out_reg.last == 1'b0, "invalid settings word not cleared")

endmodule

[sim/jmps_sample_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joint motion sample checker
// Follows the register writes and both word channels of the sampler. For
// every accepted input word it computes the expected sample and compares it,
// field by field, with the results in the order they leave the block.
// ----------------------------------------------------------------------------

module jmps_sample_checker #(
    parameter int INDEX_WIDTH = jmps_pkg::INDEX_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [jmps_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    input  logic                        pready,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [INDEX_WIDTH-1:0]      step_index,
    input  logic signed [31:0]          start_pos,
    input  logic signed [31:0]          end_pos,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [31:0]                 sample_time,
    input  logic signed [31:0]          position,
    input  logic signed [31:0]          velocity,
    input  logic signed [31:0]          acceleration,
    input  logic                        is_last,
    input  logic [1:0]                  status,
    output int                          errors,
    output int                          pending,
    output int                          checked
);
    import jmps_pkg::*;

    localparam bit [63:0] Q30_ONE = 64'd1 << 30;
    localparam bit [63:0] CAP     = 64'd1 << 34;

    logic [1:0]  mode_q;
    logic [31:0] duration_q;
    logic [31:0] step_q;
    res_t        expected_samples[$];

    // round(a*b/c), capped like the block's magnitude path
    function automatic bit [63:0] ratio_round(bit [63:0] a, bit [63:0] b, bit [63:0] c);
        bit [127:0] p;
        bit [127:0] q;
        if (c == 0)
            return CAP;
        p = {64'd0, a} * {64'd0, b} + {64'd0, c >> 1};
        if ((p >> 64) >= {64'd0, c})
            return CAP;
        q = p / {64'd0, c};
        return (q > {64'd0, CAP}) ? CAP : q[63:0];
    endfunction

    function automatic bit [63:0] q30_mul(bit [63:0] a, bit [63:0] b);
        return (a * b + (Q30_ONE >> 1)) >> 30;
    endfunction

    function automatic longint signed_mag(bit neg, bit [63:0] mag);
        if (mag > CAP)
            mag = CAP;
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fff_ffff;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic res_t predict_sample(bit [63:0] idx, logic signed [31:0] q0_in,
                                            logic signed [31:0] q1_in);
        res_t      r;
        longint    q0, delta, pos, vel, acc, h, d2h;
        bit        neg;
        bit [63:0] mag, d, dt, steps, t, s, u, s2, s3, s4, s5, dh;
        r = '0;
        q0 = q0_in;
        delta = longint'(q1_in) - q0;
        neg = delta < 0;
        mag = neg ? -delta : delta;
        d = duration_q;
        dt = step_q;
        pos = 0;
        vel = 0;
        acc = 0;
        if (dt == 0 || mode_q == MODE_BAD || (mode_q != MODE_HOLD && d == 0)) begin
            r.status = ST_INVALID;
            return r;
        end
        steps = (d + dt - 1) / dt;
        if (steps == 0)
            steps = 1;
        if (idx > steps) begin
            r.status = ST_PAST;
            return r;
        end
        // A zero-length hold repeats time zero at index one; that point is dropped.
        if (mode_q == MODE_HOLD && d == 0 && idx == 1) begin
            r.last = 1'b1;
            r.status = ST_DUP;
            return r;
        end
        t = idx * dt;
        if (t > d)
            t = d;
        if (mode_q == MODE_HOLD) begin
            pos = q0;
        end
        else if (mode_q == MODE_LINEAR) begin
            pos = q0 + signed_mag(neg, ratio_round(mag, t, d));
            vel = signed_mag(neg, ratio_round(mag, 64'd1 << 16, d));
        end
        else begin
            s = ((t << 30) + (d >> 1)) / d;
            if (s > Q30_ONE)
                s = Q30_ONE;
            u = Q30_ONE - s;
            s2 = q30_mul(s, s);
            s3 = q30_mul(s2, s);
            s4 = q30_mul(s3, s);
            s5 = q30_mul(s4, s);
            h = 10 * longint'(s3) - 15 * longint'(s4) + 6 * longint'(s5);
            if (h < 0)
                h = 0;
            if (h > longint'(Q30_ONE))
                h = Q30_ONE;
            dh = 30 * q30_mul(s2, q30_mul(u, u));
            d2h = 60 * longint'(s) - 180 * longint'(s2) + 120 * longint'(s3);
            pos = q0 + signed_mag(neg, ratio_round(mag, h, Q30_ONE));
            vel = signed_mag(neg, ratio_round(mag, dh, d << 14));
            acc = signed_mag(neg != (d2h < 0),
                             ratio_round(mag << 2, (d2h < 0) ? -d2h : d2h, d * d));
        end
        r.t = t[31:0];
        r.pos = clip32(pos);
        r.vel = clip32(vel);
        r.acc = clip32(acc);
        r.last = (idx == steps);
        r.status = ST_OK;
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("%0t: %s mismatch, got %0d, expected %0d", $realtime, field, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n) begin
            mode_q <= MODE_RESET;
            duration_q <= DURATION_RESET;
            step_q <= STEP_RESET;
            expected_samples.delete();
            errors <= 0;
            checked <= 0;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_MODE:     mode_q <= pwdata[1:0];
                    REG_DURATION: duration_q <= pwdata;
                    REG_STEP:     step_q <= pwdata;
                    default:      ;
                endcase
            end
            if (in_valid && in_ready)
                expected_samples.insert(expected_samples.size(),
                                        predict_sample(step_index, start_pos, end_pos));
            if (out_valid && out_ready) begin
                checked <= checked + 1;
                if (expected_samples.size() == 0) begin
                    $display("%0t: result word with nothing expected", $realtime);
                    errors++;
                end
                else begin
                    want = expected_samples.pop_front();
                    if (sample_time !== want.t)
                        report_mismatch("sample_time", sample_time, want.t);
                    if (position !== want.pos)
                        report_mismatch("position", position, want.pos);
                    if (velocity !== want.vel)
                        report_mismatch("velocity", velocity, want.vel);
                    if (acceleration !== want.acc)
                        report_mismatch("acceleration", acceleration, want.acc);
                    if (is_last !== want.last)
                        report_mismatch("is_last", is_last, want.last);
                    if (status !== want.status)
                        report_mismatch("status", status, want.status);
                end
            end
        end
    end

    assign pending = expected_samples.size();

endmodule

[sim/tb_joint_motion_profile_sampler_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joint motion profile sampler testbench
// Drives sample words through a sequence of register settings (hold, linear,
// quintic, invalid and extreme values) with random flow control on both
// sides in most phases; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------

module tb_joint_motion_profile_sampler_unit;
    import jmps_pkg::*;

    localparam int IW       = 20;
    localparam int N_PHASES = 15;
    localparam int PER_PHASE = 100;
    localparam longint LIMIT = 2000000;

    logic              clk;
    logic              rst_n;
    logic              psel, penable, pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid, in_ready;
    logic [IW-1:0]     step_index;
    logic signed [31:0] start_pos, end_pos;
    logic              out_valid, out_ready;
    logic [31:0]       sample_time;
    logic signed [31:0] position, velocity, acceleration;
    logic              is_last;
    logic [1:0]        status;
    int                errors, pending, checked;
    int                send_idle_pct, recv_idle_pct;
    longint            cycles;
    logic [31:0]       cur_dur, cur_step;

    joint_motion_profile_sampler_unit #(.INDEX_WIDTH(IW)) dut (.*);

    jmps_sample_checker #(.INDEX_WIDTH(IW)) u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (cycles > LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apply_settings(logic [1:0] m, logic [31:0] d, logic [31:0] s);
        write_reg(REG_MODE, {30'd0, m});
        write_reg(REG_DURATION, d);
        write_reg(REG_STEP, s);
        cur_dur = d;
        cur_step = s;
    endtask

    task automatic send_word(logic [IW-1:0] idx, logic signed [31:0] a, logic signed [31:0] b);
        in_valid <= 1'b1;
        step_index <= idx;
        start_pos <= a;
        end_pos <= b;
        do
            @(posedge clk);
        while (!in_ready);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    function automatic logic [IW-1:0] pick_index();
        longint unsigned steps;
        if (cur_step == 0)
            steps = 8;
        else
            steps = (longint'(cur_dur) + cur_step - 1) / cur_step;
        if (steps == 0)
            steps = 1;
        case ($urandom_range(9))
            0: return IW'($urandom);
            1: return IW'(steps);
            2: return IW'(steps + 1);
            default: return IW'($urandom_range(0, 32'((steps > 1048575) ? 1048575 : steps)));
        endcase
    endfunction

    function automatic logic signed [31:0] pick_pos();
        case ($urandom_range(7))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2, 3: return $urandom;
            default: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        endcase
    endfunction

    task automatic drain();
        in_valid <= 1'b0;
        // Let the checker record the last accepted word before looking at the count.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    initial
    begin
        cycles = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        step_index = '0;
        start_pos = '0;
        end_pos = '0;
        out_ready = 1'b0;
        send_idle_pct = 18;
        recv_idle_pct = 82;
        cur_dur = DURATION_RESET;
        cur_step = STEP_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: ends of the move, past the end, and the extreme positions.
        send_word(0, 32'sh8000_0000, 32'sh7fff_ffff);
        send_word(101, 32'sh8000_0000, 32'sh7fff_ffff);
        send_word(50, 32'sh7fff_ffff, 32'sh8000_0000);
        send_word(102, 32'sh0001_0000, 32'sh0002_0000);
        send_word('1, 32'sh0001_0000, 32'sh0002_0000);
        send_word(25, 32'sh1234_5678, 32'sh1234_5678);
        send_word(1, 0, 32'sh7fff_ffff);
        send_word(100, -32'sh0003_0000, 32'sh0005_0000);
        drain();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph == 5) begin
                send_idle_pct = 82;
                recv_idle_pct = 18;
            end
            else if (ph == 10) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (ph)
                0:  apply_settings(MODE_LINEAR, 32'h0003_0000, 32'd6554);
                1:  apply_settings(MODE_HOLD, 0, 1);
                2:  apply_settings(MODE_HOLD, 32'h0001_0000, 0);
                3:  apply_settings(MODE_BAD, 32'h0001_0000, 655);
                4:  apply_settings(MODE_LINEAR, 0, 655);
                5:  apply_settings(MODE_QUINTIC, 32'hffff_ffff, 32'h00ff_ffff);
                6:  apply_settings(MODE_QUINTIC, 1, 32'hffff_ffff);
                7:  apply_settings(MODE_LINEAR, 32'hffff_ffff, 32'hffff_ffff);
                8:  apply_settings(MODE_QUINTIC, 100, 1);
                9:  apply_settings(MODE_QUINTIC, 0, 5);
                10: apply_settings(MODE_HOLD, 32'h0002_0000, 32'd1000);
                11: apply_settings(MODE_QUINTIC, DURATION_RESET, STEP_RESET);
                default: apply_settings($urandom_range(0, 2), $urandom,
                                        ($urandom >> $urandom_range(8, 20)) + 1);
            endcase
            for (int k = 0; k < PER_PHASE; k++)
                send_word(pick_index(), pick_pos(), pick_pos());
            drain();
        end

        $display("Checked %0d samples over %0d register settings,", checked, N_PHASES + 1);
        $display("covering hold, linear, quintic, invalid and past-end cases.");
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/jmps_pkg.sv
sv/jmps_div.sv
sv/jmps_poly.sv
sv/joint_motion_profile_sampler_unit.sv
sim/jmps_sample_checker.sv
sim/tb_joint_motion_profile_sampler_unit.sv
